// File: rtl/pfa_pkg.sv
// Shared types, codes and defaults for the page free-list allocator.
package pfa_pkg;

	localparam int ADDR_W      = 32;
	localparam int OP_W        = 2;
	localparam int STATUS_W    = 2;
	localparam int CFG_INDEX_W = 2;

	// Default configuration of the pools.
	localparam int PAGE_SLOTS_DFLT  = 32768;
	localparam int SUPER_SLOTS_DFLT = 8;
	localparam int PAGE_SHIFT_DFLT  = 12;
	localparam int SUPER_SHIFT_DFLT = 21;
	localparam int ADDR_BITS_DFLT   = 32;

	// Request codes.
	localparam logic [OP_W-1:0] OP_ALLOC_PAGE  = 2'd0;
	localparam logic [OP_W-1:0] OP_FREE_PAGE   = 2'd1;
	localparam logic [OP_W-1:0] OP_ALLOC_SUPER = 2'd2;
	localparam logic [OP_W-1:0] OP_FREE_SUPER  = 2'd3;

	// Response status codes.
	localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BAD   = 2'd2;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

	// Configuration register indexes and their reset values.
	localparam logic [CFG_INDEX_W-1:0] REG_LOW_BOUND = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_PHYS_TOP  = 2'd1;
	localparam logic [ADDR_W-1:0] LOW_BOUND_RST = 32'h8000_0000;
	localparam logic [ADDR_W-1:0] PHYS_TOP_RST  = 32'h8800_0000;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [ADDR_W-1:0] address;
	} req_t;

	typedef struct packed {
		logic [ADDR_W-1:0]   granted_address;
		logic [STATUS_W-1:0] status;
	} rsp_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic latch;    // capture the accepted request
		logic exec;     // check, update count, write or start a read
		logic rd_done;  // stack read data is valid, form the grant
		logic out_load; // move the finished result to the output register
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic needs_read; // allocate request on a pool that is not empty
	} dp_status_t;

	// Index width of a store with the given number of entries.
	function automatic int idx_bits(input int depth);
		return (depth > 1) ? $clog2(depth) : 1;
	endfunction

endpackage

// File: rtl/pfa_ram.sv
// Generic single-port RAM with registered read data.
module pfa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                clk,
	input  logic                                we,
	input  logic [pfa_pkg::idx_bits(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]                    wdata,
	output logic [WIDTH-1:0]                    rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/pfa_datapath.sv
// Datapath: configuration registers, pool counts, stack memories and result registers.
module pfa_datapath #(
	parameter int PAGE_SLOTS  = pfa_pkg::PAGE_SLOTS_DFLT,
	parameter int SUPER_SLOTS = pfa_pkg::SUPER_SLOTS_DFLT,
	parameter int PAGE_SHIFT  = pfa_pkg::PAGE_SHIFT_DFLT,
	parameter int SUPER_SHIFT = pfa_pkg::SUPER_SHIFT_DFLT,
	parameter int ADDR_BITS   = pfa_pkg::ADDR_BITS_DFLT
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	input  logic [pfa_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [pfa_pkg::ADDR_W-1:0]           cfg_data,
	input  pfa_pkg::req_t                        req,
	input  pfa_pkg::ctrl_cmd_t                   cmd,
	output pfa_pkg::dp_status_t                  stat,
	output pfa_pkg::rsp_t                        rsp
);
	import pfa_pkg::*;

	// Only the low address bits that survive the 32-bit result carry a frame.
	localparam int EFF_BITS  = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
	localparam int PAGE_FW   = (EFF_BITS > PAGE_SHIFT) ? EFF_BITS - PAGE_SHIFT : 0;
	localparam int SUPER_FW  = (EFF_BITS > SUPER_SHIFT) ? EFF_BITS - SUPER_SHIFT : 0;
	localparam int PAGE_RW   = (PAGE_FW > 0) ? PAGE_FW : 1;
	localparam int SUPER_RW  = (SUPER_FW > 0) ? SUPER_FW : 1;
	localparam logic [ADDR_W-1:0] PAGE_MASK  = ADDR_W'((64'd1 << PAGE_FW) - 64'd1);
	localparam logic [ADDR_W-1:0] SUPER_MASK = ADDR_W'((64'd1 << SUPER_FW) - 64'd1);
	localparam int PAGE_AW   = idx_bits(PAGE_SLOTS);
	localparam int SUPER_AW  = idx_bits(SUPER_SLOTS);
	localparam int PAGE_CW   = $clog2(PAGE_SLOTS + 1);
	localparam int SUPER_CW  = $clog2(SUPER_SLOTS + 1);

	logic [ADDR_W-1:0]   low_bound_q;
	logic [ADDR_W-1:0]   phys_top_q;
	logic [OP_W-1:0]     op_q;
	logic [ADDR_W-1:0]   addr_q;
	logic [PAGE_CW-1:0]  page_count_q;
	logic [SUPER_CW-1:0] super_count_q;
	rsp_t                pend_q;
	rsp_t                out_q;

	logic [PAGE_CW-1:0]  page_top;
	logic [SUPER_CW-1:0] super_top;
	logic                page_empty, page_full, super_empty, super_full;
	logic                in_range, page_bad, super_bad;
	logic                page_push, super_push;
	logic [ADDR_W-1:0]   page_frame, super_frame;
	logic [PAGE_AW-1:0]  page_addr;
	logic [SUPER_AW-1:0] super_addr;
	logic [PAGE_RW-1:0]  page_rdata;
	logic [SUPER_RW-1:0] super_rdata;
	logic [ADDR_W-1:0]   page_grant, super_grant;

	assign page_top    = page_count_q - 1'b1;
	assign super_top   = super_count_q - 1'b1;
	assign page_empty  = (page_count_q == '0);
	assign super_empty = (super_count_q == '0);
	assign page_full   = (page_count_q == PAGE_CW'(PAGE_SLOTS));
	assign super_full  = (super_count_q == SUPER_CW'(SUPER_SLOTS));

	assign in_range  = (addr_q >= low_bound_q) && (addr_q < phys_top_q);
	assign page_bad  = (addr_q[PAGE_SHIFT-1:0] != '0) || !in_range;
	assign super_bad = (addr_q[SUPER_SHIFT-1:0] != '0) || !in_range;

	assign page_push  = cmd.exec && (op_q == OP_FREE_PAGE) && !page_bad && !page_full;
	assign super_push = cmd.exec && (op_q == OP_FREE_SUPER) && !super_bad && !super_full;

	assign page_frame  = (addr_q >> PAGE_SHIFT) & PAGE_MASK;
	assign super_frame = (addr_q >> SUPER_SHIFT) & SUPER_MASK;

	// A pop reads the entry below the count, a push writes the entry at it.
	assign page_addr  = (op_q == OP_ALLOC_PAGE) ? page_top[PAGE_AW-1:0]
	                                            : page_count_q[PAGE_AW-1:0];
	assign super_addr = (op_q == OP_ALLOC_SUPER) ? super_top[SUPER_AW-1:0]
	                                             : super_count_q[SUPER_AW-1:0];

	pfa_ram #(.WIDTH(PAGE_RW), .DEPTH(PAGE_SLOTS)) u_page_ram (
		.clk  (clk),
		.we   (page_push),
		.addr (page_addr),
		.wdata(page_frame[PAGE_RW-1:0]),
		.rdata(page_rdata)
	);

	pfa_ram #(.WIDTH(SUPER_RW), .DEPTH(SUPER_SLOTS)) u_super_ram (
		.clk  (clk),
		.we   (super_push),
		.addr (super_addr),
		.wdata(super_frame[SUPER_RW-1:0]),
		.rdata(super_rdata)
	);

	assign page_grant  = ADDR_W'(page_rdata) << PAGE_SHIFT;
	assign super_grant = ADDR_W'(super_rdata) << SUPER_SHIFT;

	assign stat.needs_read = ((op_q == OP_ALLOC_PAGE) && !page_empty) ||
	                         ((op_q == OP_ALLOC_SUPER) && !super_empty);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_bound_q   <= LOW_BOUND_RST;
			phys_top_q    <= PHYS_TOP_RST;
			page_count_q  <= '0;
			super_count_q <= '0;
		end else begin
			if (cfg_valid && (cfg_index == REG_LOW_BOUND)) begin
				low_bound_q <= cfg_data;
			end
			if (cfg_valid && (cfg_index == REG_PHYS_TOP)) begin
				phys_top_q <= cfg_data;
			end
			if (cmd.exec && (op_q == OP_ALLOC_PAGE) && !page_empty) begin
				page_count_q <= page_count_q - 1'b1;
			end else if (page_push) begin
				page_count_q <= page_count_q + 1'b1;
			end
			if (cmd.exec && (op_q == OP_ALLOC_SUPER) && !super_empty) begin
				super_count_q <= super_count_q - 1'b1;
			end else if (super_push) begin
				super_count_q <= super_count_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q   <= req.op;
			addr_q <= req.address;
		end
		if (cmd.exec) begin
			pend_q.granted_address <= '0;
			case (op_q)
				OP_ALLOC_PAGE:  pend_q.status <= page_empty ? ST_EMPTY : ST_DONE;
				OP_ALLOC_SUPER: pend_q.status <= super_empty ? ST_EMPTY : ST_DONE;
				OP_FREE_PAGE:   pend_q.status <= page_bad ? ST_BAD :
				                                 (page_full ? ST_FULL : ST_DONE);
				OP_FREE_SUPER:  pend_q.status <= super_bad ? ST_BAD :
				                                 (super_full ? ST_FULL : ST_DONE);
				default:        pend_q.status <= ST_BAD;
			endcase
		end else if (cmd.rd_done) begin
			pend_q.granted_address <= (op_q == OP_ALLOC_SUPER) ? super_grant : page_grant;
			pend_q.status          <= ST_DONE;
		end
		if (cmd.out_load) begin
			out_q <= pend_q;
		end
	end

	assign rsp = out_q;

endmodule

// File: rtl/pfa_ctrl.sv
// Controller: sequences one request through check, stack access and result hand-off.
module pfa_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	input  pfa_pkg::dp_status_t stat,
	output pfa_pkg::ctrl_cmd_t  cmd
);
	import pfa_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_RDATA,
		S_HOLD
	} state_t;

	state_t state_q;
	logic   rsp_valid_q;
	logic   out_free;

	assign out_free = !rsp_valid_q || rsp_ready;

	always_comb begin
		cmd          = '0;
		cmd.latch    = (state_q == S_IDLE) && req_valid;
		cmd.exec     = (state_q == S_EXEC);
		cmd.rd_done  = (state_q == S_RDATA);
		cmd.out_load = (state_q == S_HOLD) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= stat.needs_read ? S_RDATA : S_HOLD;
				end
				S_RDATA: begin
					state_q <= S_HOLD;
				end
				S_HOLD: begin
					if (out_free) begin
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;

endmodule

// File: rtl/page_free_list_allocator_unit.sv
// Top level of the page free-list allocator: controller plus datapath.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+-----------------------------------
//   req     | in        | req_valid / req_ready | req_t: op, address
//   rsp     | out       | rsp_valid / rsp_ready | rsp_t: granted_address, status
//   cfg     | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// A request goes from the execute state to the hold state; an allocate that pops a
// non-empty pool passes the read-data state between, as the stack has a registered read.
// The controller handles one request at a time; the next request is accepted in the
// cycle after the previous result moves into the output register.
// A response word that is not taken holds in the output register; only the hand-off of
// the following result waits for it, so a new request is still accepted meanwhile.
// Reset clears both pool counts and loads the bound registers; the stacks need no
// clearing pass, since a pop only reads entries that a push wrote.
module page_free_list_allocator_unit #(
	parameter int PAGE_SLOTS  = pfa_pkg::PAGE_SLOTS_DFLT,
	parameter int SUPER_SLOTS = pfa_pkg::SUPER_SLOTS_DFLT,
	parameter int PAGE_SHIFT  = pfa_pkg::PAGE_SHIFT_DFLT,
	parameter int SUPER_SHIFT = pfa_pkg::SUPER_SHIFT_DFLT,
	parameter int ADDR_BITS   = pfa_pkg::ADDR_BITS_DFLT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	output logic                            req_ready,
	input  pfa_pkg::req_t                   req,
	output logic                            rsp_valid,
	input  logic                            rsp_ready,
	output pfa_pkg::rsp_t                   rsp,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [pfa_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [pfa_pkg::ADDR_W-1:0]      cfg_data
);
	import pfa_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t stat;

	// Configuration writes take effect in the cycle after they are offered, so the port is always ready. Writes to
	// an index past the bound registers are taken and dropped.
	assign cfg_ready = 1'b1;

	// The controller decides when a word is accepted, executed and handed out.
	pfa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// The datapath holds the bounds, both stacks with their counts, and the result.
	pfa_datapath #(
		.PAGE_SLOTS (PAGE_SLOTS),
		.SUPER_SLOTS(SUPER_SLOTS),
		.PAGE_SHIFT (PAGE_SHIFT),
		.SUPER_SHIFT(SUPER_SHIFT),
		.ADDR_BITS  (ADDR_BITS)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.req      (req),
		.cmd      (cmd),
		.stat     (stat),
		.rsp      (rsp)
	);

endmodule

// File: rtl/pfa_checker.sv
// Port-level checks of the allocator, attached to the top level by bind.
module pfa_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_ready,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input pfa_pkg::rsp_t rsp
);
	import pfa_pkg::*;

	// A response word stays offered until it is taken.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response word dropped before it was taken");

	// A stalled response word keeps its payload.
	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp))
		else $error("response payload changed while stalled");

	// Only a successful allocation carries an address.
	a_grant_only_done: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status != ST_DONE) |-> (rsp.granted_address == '0))
		else $error("address granted with a failing status");

	// Requests are worked one at a time: an accepted word closes the request port.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while the previous one is in work");

endmodule

bind page_free_list_allocator_unit pfa_checker u_pfa_checker (.*);
